[rtl/twao_pkg.sv]
// ----------------------------------------------------------------------------
// twao_pkg
// Shared widths, constants and the arctangent table for the arc odometry
// block.
// ----------------------------------------------------------------------------
package twao_pkg;

  localparam int CORDIC_STEPS = 24;
  localparam int FRAC_BITS    = 16;

  // field widths
  localparam int CFG_W  = 22;
  localparam int CIDX_W = 2;
  localparam int OFF_W  = 22;
  localparam int DIA_W  = 4;
  localparam int CD_W   = 32;
  localparam int HD_W   = 16;
  localparam int OR_W   = 17;
  localparam int POS_W  = 32;
  localparam int ANG_W  = 32;

  // internal widths
  localparam int DCD_W  = OR_W + 1;
  localparam int DD_W   = CD_W + DIA_W + 1;
  localparam int DIV_NW = 52;
  localparam int DIV_DW = 18;
  localparam int CS_W   = FRAC_BITS + 8;
  localparam int MUL_AW = 40;
  localparam int MUL_BW = (CS_W > 28) ? CS_W : 28;
  localparam int MUL_PW = MUL_AW + MUL_BW;
  localparam int TERM_W = 39;
  localparam int QS_W   = DIV_NW + 2;

  // arithmetic constants
  localparam longint GAIN_Q30   = 64'sd652032874;
  localparam longint GAIN_INIT  = (GAIN_Q30 + (64'sd1 <<< (29 - FRAC_BITS)))
                                  >>> (30 - FRAC_BITS);
  localparam longint PI_TRAVEL  = 64'sd95950490;
  localparam int     PI_SHIFT   = 24;
  localparam longint TERM_LIM   = (64'sd1 <<< 38) - 64'sd1;
  localparam longint HALF_CD    = 64'sd36000;
  localparam longint TURN_HALF  = 64'sd72000;
  localparam int     UNIT_SHIFT = 16;

  // register indexes
  localparam logic [CIDX_W-1:0] REG_FWD_OFF  = 2'd0;
  localparam logic [CIDX_W-1:0] REG_SIDE_OFF = 2'd1;
  localparam logic [CIDX_W-1:0] REG_DIA      = 2'd2;

  // operation codes
  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_SET    = 1'b1;

  function automatic logic [ANG_W-1:0] atan_at(input logic [4:0] i);
    logic [ANG_W-1:0] v;
    case (i)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      5'd24: v = 32'd41;
      5'd25: v = 32'd20;
      5'd26: v = 32'd10;
      5'd27: v = 32'd5;
      5'd28: v = 32'd3;
      5'd29: v = 32'd1;
      5'd30: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

[rtl/twao_in_if.sv]
// ----------------------------------------------------------------------------
// twao_in_if
// Input channel: sensor update or set-pose word with valid/ready.
// ----------------------------------------------------------------------------
interface twao_in_if;
  logic                                valid;
  logic                                ready;
  logic                                operation;
  logic signed [twao_pkg::CD_W-1:0]    forward_count;
  logic signed [twao_pkg::CD_W-1:0]    sideways_count;
  logic        [twao_pkg::HD_W-1:0]    heading;
  logic signed [twao_pkg::POS_W-1:0]   set_x;
  logic signed [twao_pkg::POS_W-1:0]   set_y;

  modport source (
    output valid, operation, forward_count, sideways_count, heading, set_x, set_y,
    input  ready
  );
  modport sink (
    input  valid, operation, forward_count, sideways_count, heading, set_x, set_y,
    output ready
  );
endinterface

[rtl/twao_out_if.sv]
// ----------------------------------------------------------------------------
// twao_out_if
// Result channel: pose word with valid/ready.
// ----------------------------------------------------------------------------
interface twao_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [twao_pkg::POS_W-1:0]   x_pos;
  logic signed [twao_pkg::POS_W-1:0]   y_pos;
  logic        [twao_pkg::OR_W-1:0]    orientation;

  modport source (
    output valid, x_pos, y_pos, orientation,
    input  ready
  );
  modport sink (
    input  valid, x_pos, y_pos, orientation,
    output ready
  );
endinterface

[rtl/twao_div.sv]
// ----------------------------------------------------------------------------
// twao_div
// Bit-serial restoring divider, one quotient bit per cycle, unsigned.
// ----------------------------------------------------------------------------
module twao_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [twao_pkg::DIV_NW-1:0]   dividend,
  input  logic [twao_pkg::DIV_DW-1:0]   divisor,
  output logic                          done,
  output logic [twao_pkg::DIV_NW-1:0]   quot
);
  import twao_pkg::*;

  localparam int CNT_W = $clog2(DIV_NW);

  logic [DIV_NW-1:0] dq_r;
  logic [DIV_DW-1:0] rem_r;
  logic [DIV_DW-1:0] dsr_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [DIV_DW:0]   trial;
  logic [DIV_DW:0]   diff;
  logic              ge;

  assign trial = {rem_r, dq_r[DIV_NW-1]};
  assign ge    = trial >= {1'b0, dsr_r};
  assign diff  = trial - {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        dq_r   <= dividend;
        rem_r  <= '0;
        dsr_r  <= divisor;
      end else if (busy_r) begin
        // quotient bits shift in behind the dividend bits
        dq_r  <= {dq_r[DIV_NW-2:0], ge};
        rem_r <= ge ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_NW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = dq_r;

endmodule

[rtl/twao_mul.sv]
// ----------------------------------------------------------------------------
// twao_mul
// Bit-serial signed shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module twao_mul (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic signed [twao_pkg::MUL_AW-1:0]   a,
  input  logic signed [twao_pkg::MUL_BW-1:0]   b,
  output logic                                 done,
  output logic signed [twao_pkg::MUL_PW-1:0]   prod
);
  import twao_pkg::*;

  localparam int CNT_W = $clog2(MUL_BW);

  logic signed [MUL_PW-1:0] mc_r;
  logic signed [MUL_PW-1:0] acc_r;
  logic        [MUL_BW-1:0] mp_r;
  logic        [CNT_W-1:0]  cnt_r;
  logic                     busy_r;
  logic                     done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        acc_r  <= '0;
        // fold the sign of b into the multiplicand, walk |b|
        mc_r   <= b[MUL_BW-1] ? -MUL_PW'(a) : MUL_PW'(a);
        mp_r   <= b[MUL_BW-1] ? MUL_BW'(-b) : MUL_BW'(b);
      end else if (busy_r) begin
        if (mp_r[0]) begin
          acc_r <= acc_r + mc_r;
        end
        mc_r  <= mc_r <<< 1;
        mp_r  <= mp_r >> 1;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(MUL_BW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

[rtl/twao_cordic.sv]
// ----------------------------------------------------------------------------
// twao_cordic
// Iterative rotation-mode CORDIC, one micro-rotation per cycle, giving sine
// and cosine of a binary angle with the gain folded into the start vector.
// ----------------------------------------------------------------------------
module twao_cordic (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic [twao_pkg::ANG_W-1:0]         angle,
  output logic                               done,
  output logic signed [twao_pkg::CS_W-1:0]   cos_val,
  output logic signed [twao_pkg::CS_W-1:0]   sin_val
);
  import twao_pkg::*;

  localparam int CNT_W = $clog2(CORDIC_STEPS);
  localparam int Z_W   = ANG_W + 2;

  logic signed [CS_W-1:0] x_r;
  logic signed [CS_W-1:0] y_r;
  logic signed [Z_W-1:0]  z_r;
  logic        [1:0]      q_r;
  logic        [CNT_W-1:0] cnt_r;
  logic                   busy_r;
  logic                   done_r;
  logic [ANG_W-1:0]       qa;
  logic [ANG_W-1:0]       zs;
  logic signed [CS_W-1:0] dx;
  logic signed [CS_W-1:0] dy;
  logic signed [Z_W-1:0]  at;

  // nearest quarter turn, residue in about +-45 degrees
  assign qa = angle + (ANG_W'(1) << (ANG_W - 3));
  assign zs = angle - {qa[ANG_W-1 -: 2], {(ANG_W - 2){1'b0}}};
  assign dx = y_r >>> cnt_r;
  assign dy = x_r >>> cnt_r;
  assign at = $signed({2'b00, atan_at(5'(cnt_r))});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        q_r    <= qa[ANG_W-1 -: 2];
        z_r    <= Z_W'($signed(zs));
        x_r    <= CS_W'(GAIN_INIT);
        y_r    <= '0;
      end else if (busy_r) begin
        if (!z_r[Z_W-1]) begin
          x_r <= x_r - dx;
          y_r <= y_r + dy;
          z_r <= z_r - at;
        end else begin
          x_r <= x_r + dx;
          y_r <= y_r - dy;
          z_r <= z_r + at;
        end
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(CORDIC_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    case (q_r)
      2'd0: begin
        cos_val = x_r;
        sin_val = y_r;
      end
      2'd1: begin
        cos_val = -y_r;
        sin_val = x_r;
      end
      2'd2: begin
        cos_val = -x_r;
        sin_val = -y_r;
      end
      default: begin
        cos_val = y_r;
        sin_val = -x_r;
      end
    endcase
  end

  assign done = done_r;

endmodule

[rtl/two_wheel_arc_odometry.sv]
// ----------------------------------------------------------------------------
// two_wheel_arc_odometry
// Arc-method pose tracker from two tracking wheels and a heading sensor,
// sequenced over a shared bit-serial divider, multiplier and CORDIC.
//
//   port      dir   handshake         word
//   in_ch     in    valid/ready       operation, counts, heading, set_x/y
//   out_ch    out   valid/ready       x_pos, y_pos, orientation
//   cfg_*     in    cfg_we only       register index and data
//
// A set-pose word goes straight to the result stage; an update runs the
// 52-step divider (two passes when the heading is unchanged, four otherwise),
// the 28-step multiplier and the 24-step CORDIC.
// One word is in work at a time; in_ch.ready is high only when idle.
// A finished pose waits in the output register if out_ch stalls, and the
// next word may be taken meanwhile. Reset is synchronous, no clearing pass.
// ----------------------------------------------------------------------------
module two_wheel_arc_odometry (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [twao_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [twao_pkg::CFG_W-1:0]    cfg_data,
  twao_in_if.sink                       in_ch,
  twao_out_if.source                    out_ch
);
  import twao_pkg::*;

  typedef enum logic [10:0] {
    ST_IDLE = 11'b000_0000_0001,
    ST_ANG1 = 11'b000_0000_0010,
    ST_COR1 = 11'b000_0000_0100,
    ST_DIVS = 11'b000_0000_1000,
    ST_MULS = 11'b000_0001_0000,
    ST_DIVF = 11'b000_0010_0000,
    ST_MULF = 11'b000_0100_0000,
    ST_ANG2 = 11'b000_1000_0000,
    ST_COR2 = 11'b001_0000_0000,
    ST_ROT  = 11'b010_0000_0000,
    ST_FIN  = 11'b100_0000_0000
  } state_t;

  localparam logic signed [MUL_PW-1:0] HALF_F = MUL_PW'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [MUL_PW-1:0] HALF_P = MUL_PW'(1) <<< (PI_SHIFT - 1);
  localparam logic signed [MUL_PW-1:0] S32_MAX = MUL_PW'(64'sd2147483647);
  localparam logic signed [MUL_PW-1:0] S32_MIN = -S32_MAX - MUL_PW'(1);
  localparam logic signed [QS_W-1:0]   T_MAX = QS_W'(TERM_LIM);

  function automatic logic signed [POS_W-1:0] sat32(input logic signed [MUL_PW-1:0] v);
    logic signed [MUL_PW-1:0] c;
    c = (v > S32_MAX) ? S32_MAX : ((v < S32_MIN) ? S32_MIN : v);
    return c[POS_W-1:0];
  endfunction

  function automatic logic signed [MUL_PW-1:0] rnd_f(input logic signed [MUL_PW-1:0] v);
    return (v + HALF_F) >>> FRAC_BITS;
  endfunction

  // config and tracked state
  logic signed [OFF_W-1:0] fto_r, sto_r;
  logic [DIA_W-1:0]        dia_r;
  logic [POS_W-1:0]        pose_x_r, pose_y_r;
  logic signed [CD_W-1:0]  last_f_r, last_s_r;
  logic [OR_W-1:0]         last_or_r;
  logic [HD_W-1:0]         hoff_r;

  // control
  state_t      state_r, state_nxt;
  logic        go_r, go_nxt;
  logic [1:0]  rot_r;
  logic        out_valid_r, out_valid_nxt;

  // work registers
  logic [OR_W-1:0]          orient_r;
  logic signed [DCD_W-1:0]  dcd_r;
  logic signed [DD_W-1:0]   dds_r, ddf_r;
  logic [ANG_W-1:0]         ang_r;
  logic signed [CS_W-1:0]   hs_r, mc_r, ms_r;
  logic signed [TERM_W-1:0] term_r;
  logic signed [POS_W-1:0]  lx_r, ly_r;
  logic signed [MUL_PW-1:0] acc_r;
  logic [POS_W-1:0]         out_x_r, out_y_r;
  logic [OR_W-1:0]          out_or_r;

  // unit hookup
  logic                     div_start, div_done;
  logic [DIV_NW-1:0]        div_nd, div_q;
  logic [DIV_DW-1:0]        div_dd;
  logic                     mul_start, mul_done;
  logic signed [MUL_AW-1:0] mul_a;
  logic signed [MUL_BW-1:0] mul_b;
  logic signed [MUL_PW-1:0] mul_p;
  logic                     cor_start, cor_done;
  logic signed [CS_W-1:0]   cor_c, cor_s;
  logic                     unit_done;

  logic                     in_acc;
  logic                     out_free;
  logic                     dcd_zero;
  logic [OR_W-1:0]          orient_in;
  logic signed [CD_W-1:0]   df_in, ds_in;
  logic [DCD_W-1:0]         dcd_mag, sum_mag, ang_mag;
  logic [DD_W-1:0]          dd_mag;
  logic signed [DD_W-1:0]   dd_sel;
  logic                     qneg;
  logic signed [QS_W-1:0]   qs, tsum;
  logic signed [MUL_PW-1:0] chord_v;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign dcd_zero    = (dcd_r == '0);

  assign orient_in = {1'b0, in_ch.heading} + {1'b0, hoff_r};
  assign df_in     = in_ch.forward_count - last_f_r;
  assign ds_in     = in_ch.sideways_count - last_s_r;

  // divider operands
  assign dcd_mag = dcd_r[DCD_W-1] ? DCD_W'(-dcd_r) : DCD_W'(dcd_r);
  assign sum_mag = {1'b0, orient_r} + {1'b0, last_or_r};
  assign ang_mag = (state_r == ST_ANG2) ? sum_mag : dcd_mag;
  assign dd_sel  = (state_r == ST_DIVF || state_r == ST_MULF) ? ddf_r : dds_r;
  assign dd_mag  = dd_sel[DD_W-1] ? DD_W'(-dd_sel) : DD_W'(dd_sel);

  always_comb begin
    if (state_r == ST_DIVS || state_r == ST_DIVF) begin
      div_nd = DIV_NW'(dd_mag) << UNIT_SHIFT;
      div_dd = DIV_DW'(dcd_mag);
    end else begin
      // half of the angle in centidegrees to a binary angle, rounded
      div_nd = (DIV_NW'(ang_mag) << ANG_W) + DIV_NW'(HALF_CD);
      div_dd = DIV_DW'(TURN_HALF);
    end
  end

  // signed quotient plus twice the tracker offset, clamped
  assign qneg = dd_sel[DD_W-1] ^ dcd_r[DCD_W-1];
  assign qs   = qneg ? -$signed({2'b00, div_q}) : $signed({2'b00, div_q});
  assign tsum = qs + (QS_W'((state_r == ST_DIVF) ? fto_r : sto_r) <<< 1);

  // multiplier operands
  always_comb begin
    if (state_r == ST_ROT) begin
      mul_a = MUL_AW'(rot_r[0] ? ly_r : lx_r);
      mul_b = MUL_BW'((rot_r[0] ^ rot_r[1]) ? ms_r : mc_r);
    end else if (dcd_zero) begin
      mul_a = MUL_AW'(dd_sel);
      mul_b = MUL_BW'(PI_TRAVEL);
    end else begin
      mul_a = MUL_AW'(term_r);
      mul_b = MUL_BW'(hs_r);
    end
  end

  assign chord_v = dcd_zero ? ((mul_p + HALF_P) >>> PI_SHIFT) : rnd_f(mul_p);

  assign div_start = (state_r == ST_ANG1 || state_r == ST_ANG2 ||
                      state_r == ST_DIVS || state_r == ST_DIVF) && !go_r;
  assign mul_start = (state_r == ST_MULS || state_r == ST_MULF ||
                      state_r == ST_ROT) && !go_r;
  assign cor_start = (state_r == ST_COR1 || state_r == ST_COR2) && !go_r;
  assign unit_done = div_done || mul_done || cor_done;

  twao_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_nd),
    .divisor  (div_dd),
    .done     (div_done),
    .quot     (div_q)
  );

  twao_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_p)
  );

  twao_cordic u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cor_start),
    .angle   (ang_r),
    .done    (cor_done),
    .cos_val (cor_c),
    .sin_val (cor_s)
  );

  always_comb begin
    state_nxt = state_r;
    go_nxt    = go_r;
    if (div_start || mul_start || cor_start) begin
      go_nxt = 1'b1;
    end else if (unit_done) begin
      go_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = (in_ch.operation == OP_SET) ? ST_FIN : ST_ANG1;
        end
      end
      ST_ANG1: if (div_done) state_nxt = ST_COR1;
      ST_COR1: if (cor_done) state_nxt = dcd_zero ? ST_MULS : ST_DIVS;
      ST_DIVS: if (div_done) state_nxt = ST_MULS;
      ST_MULS: if (mul_done) state_nxt = dcd_zero ? ST_MULF : ST_DIVF;
      ST_DIVF: if (div_done) state_nxt = ST_MULF;
      ST_MULF: if (mul_done) state_nxt = ST_ANG2;
      ST_ANG2: if (div_done) state_nxt = ST_COR2;
      ST_COR2: if (cor_done) state_nxt = ST_ROT;
      ST_ROT:  if (mul_done && rot_r == 2'd3) state_nxt = ST_FIN;
      ST_FIN:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (state_r == ST_FIN && out_free) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      go_r        <= 1'b0;
      rot_r       <= '0;
      out_valid_r <= 1'b0;
      fto_r       <= '0;
      sto_r       <= '0;
      dia_r       <= DIA_W'(2);
      pose_x_r    <= '0;
      pose_y_r    <= '0;
      last_f_r    <= '0;
      last_s_r    <= '0;
      last_or_r   <= '0;
      hoff_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      go_r        <= go_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_FWD_OFF:  fto_r <= $signed(cfg_data[OFF_W-1:0]);
          REG_SIDE_OFF: sto_r <= $signed(cfg_data[OFF_W-1:0]);
          REG_DIA:      dia_r <= cfg_data[DIA_W-1:0];
          default: ;
        endcase
      end
      if (state_r == ST_IDLE) begin
        rot_r <= '0;
      end
      if (in_acc) begin
        last_f_r <= in_ch.forward_count;
        last_s_r <= in_ch.sideways_count;
        if (in_ch.operation == OP_SET) begin
          pose_x_r  <= in_ch.set_x;
          pose_y_r  <= in_ch.set_y;
          last_or_r <= {1'b0, in_ch.heading};
          hoff_r    <= in_ch.heading;
        end
      end
      if (state_r == ST_ROT && mul_done) begin
        rot_r <= rot_r + 2'd1;
        if (rot_r == 2'd1) begin
          pose_x_r <= pose_x_r + POS_W'(rnd_f(acc_r - mul_p));
        end
        if (rot_r == 2'd3) begin
          pose_y_r  <= pose_y_r + POS_W'(rnd_f(acc_r + mul_p));
          last_or_r <= orient_r;
        end
      end
    end
  end

  // datapath without reset
  always_ff @(posedge clk) begin
    if (in_acc) begin
      orient_r <= orient_in;
      dcd_r    <= $signed({1'b0, orient_in}) - $signed({1'b0, last_or_r});
      dds_r    <= $signed({1'b0, dia_r}) * ds_in;
      ddf_r    <= $signed({1'b0, dia_r}) * df_in;
    end
    if (div_done) begin
      if (state_r == ST_ANG1) begin
        ang_r <= dcd_r[DCD_W-1] ? (ANG_W'(0) - div_q[ANG_W-1:0]) : div_q[ANG_W-1:0];
      end else if (state_r == ST_ANG2) begin
        ang_r <= ANG_W'(0) - div_q[ANG_W-1:0];
      end else begin
        term_r <= (tsum > T_MAX) ? TERM_W'(T_MAX) :
                  ((tsum < -T_MAX) ? TERM_W'(-T_MAX) : TERM_W'(tsum));
      end
    end
    if (cor_done) begin
      if (state_r == ST_COR1) begin
        hs_r <= cor_s;
      end else begin
        mc_r <= cor_c;
        ms_r <= cor_s;
      end
    end
    if (mul_done) begin
      if (state_r == ST_MULS) begin
        lx_r <= sat32(chord_v);
      end
      if (state_r == ST_MULF) begin
        ly_r <= sat32(chord_v);
      end
      if (state_r == ST_ROT) begin
        acc_r <= mul_p;
      end
    end
    if (state_r == ST_FIN && out_free) begin
      out_x_r  <= pose_x_r;
      out_y_r  <= pose_y_r;
      out_or_r <= last_or_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.x_pos       = out_x_r;
  assign out_ch.y_pos       = out_y_r;
  assign out_ch.orientation = out_or_r;

  // a set-pose word goes straight to the result stage
  a_set_fast: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.operation == OP_SET) |=> state_r == ST_FIN)
    else $error("set-pose word did not go to result stage");

  // a unit is only in flight while a word is in work
  a_go_busy: assert property (@(posedge clk) disable iff (!rst_n)
    go_r |-> state_r != ST_IDLE && state_r != ST_FIN)
    else $error("unit running outside of a word");

  // leaving the result stage always presents a word
  a_fin_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && out_free) |=> out_valid_r && state_r == ST_IDLE)
    else $error("result not presented");

  // a held result is dropped only when taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_valid_r) |-> $past(out_ch.ready))
    else $error("result dropped without being taken");

endmodule

[test/tb_two_wheel_arc_odometry.sv]
// ----------------------------------------------------------------------------
// tb_two_wheel_arc_odometry
// Drives update and set-pose words into the arc odometry tracker under
// several register settings, with random gaps and output stalls. Each pose
// word is checked against a bit-true predictor kept inside the bench.
// ----------------------------------------------------------------------------
module tb_two_wheel_arc_odometry;
  import twao_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic        op;
    logic [31:0] fwd;
    logic [31:0] side;
    logic [15:0] head;
    logic [31:0] sx;
    logic [31:0] sy;
  } sensor_word_t;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [16:0] o;
  } pose_t;

  localparam logic [31:0] ARC_TAB [0:31] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
    83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
    81, 41, 20, 10, 5, 3, 1, 1, 0};

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CIDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  twao_in_if  in_ch ();
  twao_out_if out_ch ();

  two_wheel_arc_odometry uut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_ch(in_ch), .out_ch(out_ch)
  );

  // predictor copy of registers and state
  longint      fwd_off_m, side_off_m, dia_m;
  logic [31:0] px_m, py_m, last_f_m, last_s_m;
  logic [16:0] last_o_m;
  logic [15:0] hoff_m;

  sensor_word_t word_q[$];
  pose_t        pose_expected_q[$];
  sensor_word_t cur_word;
  int           errors;
  int           in_gap, out_stall;
  bit           no_idle;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 96) return $urandom_range(1, 4);
    return $urandom_range(20, 500);
  endfunction

  function automatic logic [31:0] half_turn_angle(longint cd);
    longint unsigned mag, a;
    mag = (cd < 0) ? -cd : cd;
    a = ((mag << 32) + 64'd36000) / 64'd72000;
    return (cd < 0) ? (32'd0 - a[31:0]) : a[31:0];
  endfunction

  function automatic void rotate_unit(input logic [31:0] a, output longint c,
                                      output longint s);
    logic [1:0]  q;
    logic [31:0] r;
    longint      x, y, z, dx, dy;
    q = 2'((a + 32'h2000_0000) >> 30);
    r = a - {q, 30'b0};
    z = longint'(signed'(r));
    x = GAIN_INIT;
    y = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(ARC_TAB[i]);
      end else begin
        x += dx; y -= dy; z += longint'(ARC_TAB[i]);
      end
    end
    case (q)
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  function automatic longint clip(longint v, longint lim_lo, longint lim_hi);
    return (v < lim_lo) ? lim_lo : ((v > lim_hi) ? lim_hi : v);
  endfunction

  function automatic longint chord_len(longint delta, longint off, longint dcd, longint hs);
    longint v, term;
    if (dcd == 0) begin
      v = (dia_m * delta * 64'sd95950490 + (64'sd1 <<< 23)) >>> 24;
    end else begin
      term = (dia_m * delta * 64'sd65536) / dcd + 2 * off;
      term = clip(term, -((64'sd1 <<< 38) - 1), (64'sd1 <<< 38) - 1);
      v = (hs * term + (64'sd1 <<< 15)) >>> 16;
    end
    return clip(v, -64'sd2147483648, 64'sd2147483647);
  endfunction

  function automatic pose_t predict_pose(sensor_word_t w);
    pose_t  p;
    longint df, ds, dcd, hc, hs, mc, ms, lx, ly, dx, dy;
    logic [16:0] orient;
    if (w.op == OP_SET) begin
      px_m = w.sx; py_m = w.sy;
      last_f_m = w.fwd; last_s_m = w.side;
      last_o_m = {1'b0, w.head}; hoff_m = w.head;
      orient = {1'b0, w.head};
    end else begin
      df = longint'(signed'(32'(w.fwd - last_f_m)));
      ds = longint'(signed'(32'(w.side - last_s_m)));
      orient = {1'b0, w.head} + {1'b0, hoff_m};
      dcd = longint'(orient) - longint'(last_o_m);
      rotate_unit(half_turn_angle(dcd), hc, hs);
      lx = chord_len(ds, side_off_m, dcd, hs);
      ly = chord_len(df, fwd_off_m, dcd, hs);
      rotate_unit(32'd0 - half_turn_angle(longint'(orient) + longint'(last_o_m)), mc, ms);
      dx = (lx * mc - ly * ms + (64'sd1 <<< 15)) >>> 16;
      dy = (lx * ms + ly * mc + (64'sd1 <<< 15)) >>> 16;
      px_m = px_m + dx[31:0];
      py_m = py_m + dy[31:0];
      last_f_m = w.fwd; last_s_m = w.side; last_o_m = orient;
    end
    p.x = px_m; p.y = py_m; p.o = orient;
    return p;
  endfunction

  // driver
  always @(posedge clk) begin
    logic nv;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      nv = in_ch.valid;
      if (in_ch.valid && in_ch.ready) begin
        pose_expected_q.push_back(predict_pose(cur_word));
        nv = 1'b0;
      end
      if (!nv) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (word_q.size() > 0) begin
          cur_word = word_q.pop_front();
          in_ch.operation      <= cur_word.op;
          in_ch.forward_count  <= cur_word.fwd;
          in_ch.sideways_count <= cur_word.side;
          in_ch.heading        <= cur_word.head;
          in_ch.set_x          <= cur_word.sx;
          in_ch.set_y          <= cur_word.sy;
          nv = 1'b1;
          in_gap = pick_gap();
        end
      end
      in_ch.valid <= nv;
    end
  end

  // monitor
  always @(posedge clk) begin
    pose_t e;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pose_expected_q.size() == 0) begin
          $display("%0t: unexpected word x=%h y=%h o=%h", $time, out_ch.x_pos,
                   out_ch.y_pos, out_ch.orientation);
          errors++;
        end else begin
          e = pose_expected_q.pop_front();
          if (out_ch.x_pos !== e.x) begin
            $display("%0t: x_pos expected %h actual %h", $time, e.x, out_ch.x_pos);
            errors++;
          end
          if (out_ch.y_pos !== e.y) begin
            $display("%0t: y_pos expected %h actual %h", $time, e.y, out_ch.y_pos);
            errors++;
          end
          if (out_ch.orientation !== e.o) begin
            $display("%0t: orientation expected %h actual %h", $time, e.o,
                     out_ch.orientation);
            errors++;
          end
        end
      end
      if (out_stall > 0) begin
        out_stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if ($urandom_range(0, 15) == 0) out_stall = pick_gap();
      end
    end
  end

  task automatic write_reg(input logic [CIDX_W-1:0] idx, input longint v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v[CFG_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_FWD_OFF:  fwd_off_m = longint'(signed'(v[CFG_W-1:0]));
      REG_SIDE_OFF: side_off_m = longint'(signed'(v[CFG_W-1:0]));
      default:      dia_m = longint'(v[DIA_W-1:0]);
    endcase
  endtask

  task automatic wait_drained();
    while (word_q.size() > 0 || in_ch.valid || pose_expected_q.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic void add_word(logic op, logic [31:0] f, logic [31:0] s,
                                   logic [15:0] h, logic [31:0] x, logic [31:0] y);
    sensor_word_t w;
    w.op = op; w.fwd = f; w.side = s; w.head = h; w.sx = x; w.sy = y;
    word_q.push_back(w);
  endfunction

  initial begin
    longint fo [0:7] = '{0, 1572864, -1572864, 2097151, -2097152, 327680, -65536, 1000};
    longint so [0:7] = '{0, -1572864, 1572864, -2097152, 2097151, -131072, 50000, 0};
    longint dd [0:7] = '{2, 8, 1, 15, 0, 4, 6, 3};
    logic [31:0] gf, gs;
    logic [15:0] gh;
    int r;
    rst_n = 1'b0; cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    in_ch.valid = 1'b0; in_ch.operation = OP_UPDATE; in_ch.forward_count = '0;
    in_ch.sideways_count = '0; in_ch.heading = '0; in_ch.set_x = '0; in_ch.set_y = '0;
    out_ch.ready = 1'b0;
    errors = 0; in_gap = 0; out_stall = 0; no_idle = 1'b0;
    fwd_off_m = 0; side_off_m = 0; dia_m = 2;
    px_m = '0; py_m = '0; last_f_m = '0; last_s_m = '0; last_o_m = '0; hoff_m = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: defaults first, then large offsets
    add_word(OP_UPDATE, 0, 0, 0, 0, 0);                          // straight, no travel
    add_word(OP_UPDATE, 36000, -36000, 0, 0, 0);                 // straight travel
    add_word(OP_UPDATE, 36100, -35900, 1, 0, 0);                 // smallest arc
    add_word(OP_UPDATE, 36100, -35900, 35999, 0, 0);             // large turn
    add_word(OP_SET, 32'h8000_0000, 32'h7fff_ffff, 0, 32'h8000_0000, 32'h7fff_ffff);
    add_word(OP_UPDATE, 32'h7fff_ffff, 32'h8000_0000, 0, 0, 0);  // extreme counts, wrapped travel
    add_word(OP_UPDATE, 32'h7fff_fffe, 32'h8000_0001, 9000, 0, 0);
    add_word(OP_SET, 0, 0, 16'hffff, 32'hffff_ffff, 0);         // heading beyond range
    add_word(OP_UPDATE, 100, 100, 16'hffff, 0, 0);               // orientation sums past a turn
    add_word(OP_UPDATE, 32'h8000_0000, 32'h7fff_ffff, 0, 0, 0);
    add_word(OP_SET, 0, 0, 0, 0, 0);
    wait_drained();
    write_reg(REG_FWD_OFF, 1572864);
    write_reg(REG_SIDE_OFF, -1572864);
    write_reg(REG_DIA, 8);
    add_word(OP_UPDATE, 1000, 2000, 1, 0, 0);
    add_word(OP_UPDATE, 1000, 2000, 35999, 0, 0);
    add_word(OP_UPDATE, 32'h7fff_0000, 32'h8000_ffff, 12345, 0, 0);
    add_word(OP_UPDATE, 32'h7fff_0000, 32'h8000_ffff, 12345, 0, 0);
    add_word(OP_UPDATE, 32'h0000_0001, 32'hffff_ffff, 12346, 0, 0);
    wait_drained();

    gf = 0; gs = 0; gh = 0;
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_FWD_OFF, fo[ph]);
      write_reg(REG_SIDE_OFF, so[ph]);
      write_reg(REG_DIA, dd[ph]);
      no_idle = (ph == 3);
      for (int n = 0; n < 172; n++) begin
        r = $urandom_range(0, 99);
        if (r < 5) begin
          gf = $urandom; gs = $urandom;
          gh = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 35999));
          add_word(OP_SET, gf, gs, gh, $urandom, $urandom);
        end else if (r < 10) begin
          add_word(OP_UPDATE, $urandom, $urandom, 16'($urandom), $urandom, $urandom);
        end else begin
          // realistic motion: small wheel steps, heading drifting or still
          gf += 32'($signed($urandom_range(0, 4000)) - 2000);
          gs += 32'($signed($urandom_range(0, 4000)) - 2000);
          r = $urandom_range(0, 9);
          if (r >= 3) gh = 16'(gh + $urandom_range(0, 600) - 300);
          if (gh > 35999 && $urandom_range(0, 3) != 0) gh = 16'($urandom_range(0, 35999));
          add_word(OP_UPDATE, gf, gs, gh, $urandom, $urandom);
        end
      end
      wait_drained();
    end

    repeat (500) @(posedge clk);
    if (errors == 0 && pose_expected_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #100ms;
    $display("Some tests failed");
    $finish;
  end

endmodule

[two_wheel_arc_odometry.f]
rtl/twao_pkg.sv
rtl/twao_in_if.sv
rtl/twao_out_if.sv
rtl/twao_div.sv
rtl/twao_mul.sv
rtl/twao_cordic.sv
rtl/two_wheel_arc_odometry.sv
test/tb_two_wheel_arc_odometry.sv
